/* hdl/lpc_pkg.sv */
// shared constants, types and state codes of the layered pixel compositor
package lpc_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int LAYERS     = 4;
	localparam int CHANNELS   = 4;
	localparam int LOCATIONS  = MAX_WIDTH * MAX_HEIGHT;
	localparam int LOC_W      = $clog2(LOCATIONS);
	localparam int CLR_W      = $clog2(LOCATIONS + 1);
	localparam int LAYER_W    = $clog2(LAYERS);
	localparam int DIM_W      = 7;
	localparam int AREA_W     = 2 * DIM_W - 1;
	localparam int IDX_W      = 16;
	localparam int NL_W       = 3;
	localparam int MODE_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int ALPHA_W    = 16;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LAYERS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd3;

	localparam logic [MODE_W-1:0] MODE_GRAY = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RGB  = 2'd1;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_COMP = 1'b1;

	typedef logic [CHANNELS-1:0][7:0] chan_t;

	typedef struct packed {
		logic [ALPHA_W-1:0] alpha;
		chan_t              color;
	} layer_t;

	typedef layer_t [LAYERS-1:0] word_t;

	typedef struct packed {
		logic             rd_en;
		logic             wr_en;
		logic [LOC_W-1:0] rd_addr;
		logic [LOC_W-1:0] wr_addr;
	} store_req_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_BLEND,
		ST_DONE
	} state_t;

endpackage

/* hdl/lpc_if.sv */
// request and result channel interfaces of the layered pixel compositor
interface lpc_req_if;
	logic              valid;
	logic              ready;
	logic              action;
	logic signed [7:0] row;
	logic signed [7:0] col;
	logic        [7:0] chan_0;
	logic        [7:0] chan_1;
	logic        [7:0] chan_2;
	logic        [7:0] chan_3;
	logic       [15:0] new_alpha;

	modport source(output valid, action, row, col, chan_0, chan_1, chan_2, chan_3, new_alpha,
		input ready);
	modport sink(input valid, action, row, col, chan_0, chan_1, chan_2, chan_3, new_alpha,
		output ready);
endinterface

interface lpc_rsp_if;
	logic       valid;
	logic       ready;
	logic       in_range;
	logic [7:0] out_0;
	logic [7:0] out_1;
	logic [7:0] out_2;
	logic [7:0] out_3;

	modport source(output valid, in_range, out_0, out_1, out_2, out_3, input ready);
	modport sink(input valid, in_range, out_0, out_1, out_2, out_3, output ready);
endinterface

/* hdl/lpc_store.sv */
// layer store: one word per location holding all layers, with a clearing pass after reset
module lpc_store import lpc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  store_req_t req,
	input  word_t      wr_data,
	output word_t      rd_data,
	output logic       busy
);

	word_t            mem [LOCATIONS];
	word_t            rd_q;
	logic [CLR_W-1:0] clr_q;

	assign busy    = (clr_q < CLR_W'(LOCATIONS));
	assign rd_data = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (busy) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			mem[clr_q[LOC_W-1:0]] <= '0;
		end else if (req.wr_en) begin
			mem[req.wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

endmodule

/* hdl/lpc_blend.sv */
// one alpha-over step of a single layer onto the running channel values
module lpc_blend import lpc_pkg::*; (
	input  chan_t                 acc,
	input  layer_t                layer,
	input  logic [CHANNELS-1:0]   chan_en,
	output chan_t                 acc_next
);

	logic [CHANNELS-1:0]       neg;
	logic [CHANNELS-1:0][7:0]  mag;
	logic [CHANNELS-1:0][23:0] prod;
	logic [CHANNELS-1:0][7:0]  step;

	// the step never exceeds the distance to the layer value, so no clamp is needed
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			neg[c]      = (layer.color[c] < acc[c]);
			mag[c]      = neg[c] ? (acc[c] - layer.color[c]) : (layer.color[c] - acc[c]);
			prod[c]     = 24'(mag[c]) * 24'(layer.alpha);
			step[c]     = prod[c][23:16];
			acc_next[c] = !chan_en[c] ? acc[c] :
				(neg[c] ? (acc[c] - step[c]) : (acc[c] + step[c]));
		end
	end

endmodule

/* hdl/layered_pixel_compositor.sv */
// top level of the layered pixel compositor: control, configuration and result register
// Every canvas location keeps a stack of up to four colour layers with 16-bit alpha, all
// held in one word of a single-port-read synchronous store (one read, one write per
// cycle, registered read data). A push item reads the location's word and writes it
// back with the layers moved down and the new layer on top; a push to a location
// outside the canvas neither reads nor writes the store. A composite item reads the
// word and blends one layer per cycle from the oldest in-use layer to the newest, then
// hands the item to the result register (zero layers in use counts as one and larger
// values saturate to four); a composite outside the canvas skips the blending and gives
// zero channel values. A finished composite waits only while an earlier result still
// waits to be taken. One item is in flight at a time, so same-location accesses never
// overlap. After reset the store is swept to zero, one location per cycle, during which
// no item is taken; configuration writes are taken at all times but should only be made
// while no item is in flight.
module layered_pixel_compositor import lpc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	lpc_req_if.sink               req,
	lpc_rsp_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration registers
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [NL_W-1:0]   layers_q;
	logic [MODE_W-1:0] mode_q;

	// effective configuration after saturation
	logic [DIM_W-1:0]    w_eff;
	logic [DIM_W-1:0]    h_eff;
	logic [AREA_W-1:0]   area;
	logic [NL_W-1:0]     nl_eff;
	logic [2:0]          nch;
	logic [CHANNELS-1:0] chan_en;

	// location of the incoming item
	logic signed [IDX_W-1:0] idx_prod;
	logic signed [IDX_W-1:0] idx;
	logic                    loc_ok;

	// item held while in flight
	state_t             state_q;
	state_t             state_nxt;
	logic               action_q;
	logic               ok_q;
	logic [LOC_W-1:0]   loc_q;
	layer_t             push_layer_q;
	logic [LAYER_W-1:0] d_q;
	chan_t              acc_q;

	// result register
	logic  out_valid_q;
	logic  in_range_q;
	chan_t out_q;

	// store and blend hookup
	store_req_t st_req;
	word_t      st_rd;
	word_t      st_wr;
	logic       clear_busy;
	chan_t      acc_next;
	logic       accept;
	logic       load_out;

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(64);
			height_q <= DIM_W'(64);
			layers_q <= NL_W'(4);
			mode_q   <= MODE_RGB;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				REG_LAYERS: layers_q <= cfg_data[NL_W-1:0];
				REG_MODE:   mode_q   <= cfg_data[MODE_W-1:0];
				default:    ;
			endcase
		end
	end

	// width and height saturate to the canvas maximum; zero gives an empty canvas
	assign w_eff = (width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
	assign h_eff = (height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;
	assign area  = AREA_W'(w_eff) * AREA_W'(h_eff);

	// zero layers counts as one, more than the stack depth saturates
	always_comb begin
		if (layers_q == '0) begin
			nl_eff = NL_W'(1);
		end else if (layers_q > NL_W'(LAYERS)) begin
			nl_eff = NL_W'(LAYERS);
		end else begin
			nl_eff = layers_q;
		end
	end

	// gray keeps one channel, rgb three, rgba and the unused code four
	always_comb begin
		case (mode_q)
			MODE_GRAY: nch = 3'd1;
			MODE_RGB:  nch = 3'd3;
			default:   nch = 3'd4;
		endcase
		for (int c = 0; c < CHANNELS; c++) begin
			chan_en[c] = (c < int'(nch));
		end
	end

	// linear index row*width+col, signed, in range when non-negative and below width*height
	assign idx_prod = req.row * $signed({1'b0, w_eff});
	assign idx      = idx_prod + $signed({{(IDX_W-8){req.col[7]}}, req.col});
	assign loc_ok   = !idx[IDX_W-1] && (idx[IDX_W-2:0] < (IDX_W-1)'(area));

	assign accept = req.valid && req.ready;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (!clear_busy) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (req.valid) state_nxt = ST_LOAD;
			end
			ST_LOAD: begin
				if (action_q == ACT_PUSH) begin
					state_nxt = ST_IDLE;
				end else if (ok_q) begin
					state_nxt = ST_BLEND;
				end else begin
					state_nxt = ST_DONE;
				end
			end
			ST_BLEND: begin
				if (d_q == '0) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		req.ready      = 1'b0;
		load_out       = 1'b0;
		st_req.rd_en   = 1'b0;
		st_req.wr_en   = 1'b0;
		st_req.rd_addr = idx[LOC_W-1:0];
		st_req.wr_addr = loc_q;
		unique case (state_q)
			ST_CLEAR: ;
			ST_IDLE: begin
				req.ready    = 1'b1;
				st_req.rd_en = req.valid && loc_ok;
			end
			ST_LOAD: begin
				st_req.wr_en = (action_q == ACT_PUSH) && ok_q;
			end
			ST_BLEND: ;
			ST_DONE: begin
				load_out = !out_valid_q || rsp.ready;
			end
			default: ;
		endcase
	end

	// pushed word: new layer on top, in-use layers move down, deeper ones stay
	always_comb begin
		for (int d = 0; d < LAYERS; d++) begin
			if (d == 0) begin
				st_wr[d] = push_layer_q;
			end else if (d < int'(nl_eff)) begin
				st_wr[d] = st_rd[d-1];
			end else begin
				st_wr[d] = st_rd[d];
			end
		end
	end

	lpc_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (st_req),
		.wr_data (st_wr),
		.rd_data (st_rd),
		.busy    (clear_busy)
	);

	// the layer being blended comes straight from the held read data
	lpc_blend u_blend (
		.acc      (acc_q),
		.layer    (st_rd[d_q]),
		.chan_en  (chan_en),
		.acc_next (acc_next)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			action_q    <= ACT_PUSH;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				action_q <= req.action;
				ok_q     <= loc_ok;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// item payload, layer counter and running channel values
	always_ff @(posedge clk) begin
		if (accept) begin
			loc_q              <= idx[LOC_W-1:0];
			push_layer_q.alpha <= req.new_alpha;
			push_layer_q.color <= {req.chan_3, req.chan_2, req.chan_1, req.chan_0}
				& {{8{chan_en[3]}}, {8{chan_en[2]}}, {8{chan_en[1]}}, {8{chan_en[0]}}};
			acc_q              <= '0;
		end
		if (state_q == ST_LOAD) begin
			d_q <= LAYER_W'(nl_eff - NL_W'(1));
		end else if (state_q == ST_BLEND) begin
			acc_q <= acc_next;
			d_q   <= d_q - 1'b1;
		end
		if (load_out) begin
			in_range_q <= ok_q;
			out_q      <= acc_q;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.in_range = in_range_q;
	assign rsp.out_0    = out_q[0];
	assign rsp.out_1    = out_q[1];
	assign rsp.out_2    = out_q[2];
	assign rsp.out_3    = out_q[3];

`ifndef SYNTHESIS
	// no item is taken while the store is being swept
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> !req.ready)
		else $error("item taken during store clear");

	// read and write of the store never share a cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_req.rd_en && st_req.wr_en))
		else $error("store read and write in the same cycle");

	// the load state follows an accepted item directly
	a_load_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> $past(req.valid && req.ready))
		else $error("load state without an accepted item");

	// the blend counter stays within the in-use layers
	a_blend_depth: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLEND) |-> (NL_W'(d_q) < nl_eff))
		else $error("blend layer beyond layers in use");

	// a pending result is not overwritten before it is taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(out_q)))
		else $error("result changed while stalled");
`endif

endmodule
